>>> rtl/vcc_pkg.sv
// ----------------------------------------------------------------------------
// vcc_pkg
// Shared types and constants for the VID code / voltage converter: VID
// modes, status codes, register indexes and reciprocal multipliers.
// ----------------------------------------------------------------------------
package vcc_pkg;

  localparam int UV_W   = 22;  // microvolt fields
  localparam int MV_W   = 12;  // millivolt result
  localparam int CODE_W = 10;  // encoded vid code
  localparam int VID_W  = 8;   // vid code to decode
  localparam int ENC_MV_W = 13;  // target truncated to mV (max 4194)
  localparam int NUM_W  = 18;  // encode numerator (max 135312)

  typedef enum logic [2:0] {
    MODE_VR11  = 3'd0,
    MODE_VR12  = 3'd1,
    MODE_VR13  = 3'd2,
    MODE_IMVP9 = 3'd3,
    MODE_AMD   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_ZERO   = 2'd1,
    STATUS_RANGE  = 2'd2,
    STATUS_UNSUPP = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_MODE_A   = 3'd0,
    CFG_MODE_B   = 3'd1,
    CFG_MIN_UV_A = 3'd2,
    CFG_MAX_UV_A = 3'd3,
    CFG_MIN_UV_B = 3'd4,
    CFG_MAX_UV_B = 3'd5
  } cfg_idx_t;

  // floor(x/1000) = (x * RECIP_1000) >> 32, exact for x < 2^22
  localparam logic [22:0] RECIP_1000 = 23'd4294968;
  // floor(n/5) = (n * 6554) >> 15 and floor(n/10) = (n * 6554) >> 16, n < 2^14
  localparam logic [18:0] RECIP_5_10 = 19'd6554;
  // floor(n/625) = (n * RECIP_625) >> 28, exact for n < 2^18
  localparam logic [18:0] RECIP_625  = 19'd429497;

endpackage

>>> rtl/vcc_decode.sv
// ----------------------------------------------------------------------------
// vcc_decode
// Maps an 8-bit VID code to millivolts for one VID mode, rounding to the
// nearest millivolt. Codes outside a mode's window give 0.
// ----------------------------------------------------------------------------
module vcc_decode (
  input  vcc_pkg::mode_t                mode,
  input  logic [vcc_pkg::VID_W-1:0]     vid_code,
  output logic [vcc_pkg::MV_W-1:0]      millivolts
);

  logic [7:0]  vr11_k;
  logic [12:0] vr11_x;
  logic [12:0] amd_x;
  logic [11:0] code_ext;

  // (160050 - 625k) / 100 == (6402 - 25k) / 4, same idea for the amd table
  assign vr11_k   = vid_code - 8'd2;
  assign vr11_x   = 13'd6402 - ({5'd0, vr11_k} * 13'd25);
  assign amd_x    = 13'd6202 - ({5'd0, vid_code} * 13'd25);
  assign code_ext = {4'd0, vid_code};

  always_comb begin
    millivolts = '0;
    case (mode)
      vcc_pkg::MODE_VR11: begin
        if (vid_code >= 8'h02 && vid_code <= 8'hb2) begin
          millivolts = {1'b0, vr11_x[12:2]};
        end
      end
      vcc_pkg::MODE_VR12: begin
        if (vid_code != 8'd0) begin
          millivolts = 12'd245 + (code_ext * 12'd5);
        end
      end
      vcc_pkg::MODE_VR13: begin
        if (vid_code != 8'd0) begin
          millivolts = 12'd490 + (code_ext * 12'd10);
        end
      end
      vcc_pkg::MODE_IMVP9: begin
        if (vid_code != 8'd0) begin
          millivolts = 12'd190 + (code_ext * 12'd10);
        end
      end
      vcc_pkg::MODE_AMD: begin
        if (vid_code <= 8'hd8) begin
          millivolts = {1'b0, amd_x[12:2]};
        end
      end
      default: millivolts = '0;
    endcase
  end

endmodule

>>> rtl/vid_code_voltage_converter.sv
// ----------------------------------------------------------------------------
// vid_code_voltage_converter
// VID code / millivolt converter for two regulator loops, three-stage pipe.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one word per conversion; in_cmd 0 decodes in_vid_code to mV,
//            in_cmd 1 encodes in_target_uv to a VID code. in_loop_select
//            picks the loop whose mode and min/max window apply.
//   out_*  : one word per input word, in order: out_millivolts,
//            out_code_out and out_status.
//   cfg_*  : register writes (mode and window per loop), one per cycle when
//            cfg_wr_en is high; write only while the pipe is empty.
// An accepted word passes through the stage 1, stage 2 and stage 3 registers;
// out_valid is the stage 3 valid, and the word leaves when out_ready is high.
// Throughput is one word per cycle while out_ready stays high: stage 1 selects
// the loop, checks the window and scales uV to mV with a reciprocal multiply,
// stage 2 forms the encode numerator, stage 3 divides it by the mode step with a
// second reciprocal multiply and holds the result as the output register.
// When out_ready is low the stages fill up and in_ready drops only once
// every stage holds a word; nothing is dropped or repeated.
// Synchronous reset empties the pipe and sets both loops to VR13 mode with
// a zero window.
// ----------------------------------------------------------------------------
module vid_code_voltage_converter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic                            in_loop_select,
  input  logic [vcc_pkg::VID_W-1:0]       in_vid_code,
  input  logic [vcc_pkg::UV_W-1:0]        in_target_uv,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [vcc_pkg::MV_W-1:0]        out_millivolts,
  output logic [vcc_pkg::CODE_W-1:0]      out_code_out,
  output logic [1:0]                      out_status,
  input  logic                            cfg_wr_en,
  input  logic [2:0]                      cfg_index,
  input  logic [vcc_pkg::UV_W-1:0]        cfg_wdata
);

  // configuration
  vcc_pkg::mode_t               mode_a_r, mode_b_r;
  logic [vcc_pkg::UV_W-1:0]     min_a_r, max_a_r, min_b_r, max_b_r;

  // stage 1
  logic                         v1_r;
  logic                         cmd1_r;
  vcc_pkg::mode_t               mode1_r;
  vcc_pkg::status_t             status1_r;
  logic [vcc_pkg::MV_W-1:0]     dec1_r;
  logic [vcc_pkg::ENC_MV_W-1:0] mv1_r;

  // stage 2
  logic                         v2_r;
  logic                         cmd2_r;
  vcc_pkg::mode_t               mode2_r;
  vcc_pkg::status_t             status2_r;
  logic [vcc_pkg::MV_W-1:0]     dec2_r;
  logic [vcc_pkg::NUM_W-1:0]    num2_r;
  logic                         under2_r;

  // stage 3 / output
  logic                         v3_r;
  logic [vcc_pkg::MV_W-1:0]     mv3_r;
  logic [vcc_pkg::CODE_W-1:0]   code3_r;
  vcc_pkg::status_t             status3_r;

  logic rdy1, rdy2, rdy3;
  logic in_fire;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign in_fire  = in_valid && rdy1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_a_r <= vcc_pkg::MODE_VR13;
      mode_b_r <= vcc_pkg::MODE_VR13;
      min_a_r  <= '0;
      max_a_r  <= '0;
      min_b_r  <= '0;
      max_b_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        vcc_pkg::CFG_MODE_A:   mode_a_r <= vcc_pkg::mode_t'(cfg_wdata[2:0]);
        vcc_pkg::CFG_MODE_B:   mode_b_r <= vcc_pkg::mode_t'(cfg_wdata[2:0]);
        vcc_pkg::CFG_MIN_UV_A: min_a_r  <= cfg_wdata;
        vcc_pkg::CFG_MAX_UV_A: max_a_r  <= cfg_wdata;
        vcc_pkg::CFG_MIN_UV_B: min_b_r  <= cfg_wdata;
        vcc_pkg::CFG_MAX_UV_B: max_b_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: loop select, checks, uV to mV ----------------
  vcc_pkg::mode_t               mode_sel;
  logic [vcc_pkg::UV_W-1:0]     lo_sel, hi_sel;
  vcc_pkg::status_t             status1_nxt;
  logic [vcc_pkg::MV_W-1:0]     dec1_nxt;
  logic [44:0]                  uv_prod;
  logic [vcc_pkg::ENC_MV_W-1:0] mv1_nxt;

  assign mode_sel = in_loop_select ? mode_b_r : mode_a_r;
  assign lo_sel   = in_loop_select ? min_b_r  : min_a_r;
  assign hi_sel   = in_loop_select ? max_b_r  : max_a_r;
  assign uv_prod  = {23'd0, in_target_uv} * {22'd0, vcc_pkg::RECIP_1000};
  assign mv1_nxt  = uv_prod[44:32];

  always_comb begin
    status1_nxt = vcc_pkg::STATUS_OK;
    if (in_cmd) begin
      if (in_target_uv == '0) begin
        status1_nxt = vcc_pkg::STATUS_ZERO;
      end else if (in_target_uv > hi_sel || in_target_uv < lo_sel) begin
        status1_nxt = vcc_pkg::STATUS_RANGE;
      end else begin
        case (mode_sel)
          vcc_pkg::MODE_VR12,
          vcc_pkg::MODE_VR13,
          vcc_pkg::MODE_IMVP9,
          vcc_pkg::MODE_AMD: status1_nxt = vcc_pkg::STATUS_OK;
          default:           status1_nxt = vcc_pkg::STATUS_UNSUPP;
        endcase
      end
    end
  end

  vcc_decode u_decode (
    .mode       (mode_sel),
    .vid_code   (in_vid_code),
    .millivolts (dec1_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd1_r    <= in_cmd;
      mode1_r   <= mode_sel;
      status1_r <= status1_nxt;
      dec1_r    <= dec1_nxt;
      mv1_r     <= mv1_nxt;
    end
  end

  // ---------------- stage 2: encode numerator ----------------
  logic [vcc_pkg::NUM_W-1:0]    num2_nxt;
  logic                         under2_nxt;
  logic [10:0]                  amd_diff;

  assign amd_diff = 11'd1550 - mv1_r[10:0];

  always_comb begin
    num2_nxt   = '0;
    under2_nxt = 1'b1;
    case (mode1_r)
      vcc_pkg::MODE_VR12: begin
        under2_nxt = mv1_r < 13'd250;
        num2_nxt   = {5'd0, mv1_r - 13'd248};
      end
      vcc_pkg::MODE_VR13: begin
        under2_nxt = mv1_r < 13'd500;
        num2_nxt   = {5'd0, mv1_r - 13'd495};
      end
      vcc_pkg::MODE_IMVP9: begin
        under2_nxt = mv1_r < 13'd200;
        num2_nxt   = {5'd0, mv1_r - 13'd195};
      end
      vcc_pkg::MODE_AMD: begin
        under2_nxt = mv1_r < 13'd200 || mv1_r > 13'd1550;
        num2_nxt   = ({7'd0, amd_diff} * 18'd100) + 18'd312;
      end
      default: begin
        under2_nxt = 1'b1;
        num2_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      cmd2_r    <= cmd1_r;
      mode2_r   <= mode1_r;
      status2_r <= status1_r;
      dec2_r    <= dec1_r;
      num2_r    <= num2_nxt;
      under2_r  <= under2_nxt;
    end
  end

  // ---------------- stage 3: divide by step, output register ----------------
  logic [18:0]                  recip;
  logic [36:0]                  quot_prod;
  logic [vcc_pkg::CODE_W-1:0]   quot;
  logic [vcc_pkg::CODE_W-1:0]   code3_nxt;
  logic [vcc_pkg::MV_W-1:0]     mv3_nxt;

  assign recip     = (mode2_r == vcc_pkg::MODE_AMD) ? vcc_pkg::RECIP_625
                                                    : vcc_pkg::RECIP_5_10;
  assign quot_prod = {19'd0, num2_r} * {18'd0, recip};

  always_comb begin
    quot = '0;
    case (mode2_r)
      vcc_pkg::MODE_VR12:  quot = quot_prod[24:15] + 10'd1;
      vcc_pkg::MODE_VR13:  quot = quot_prod[25:16] + 10'd1;
      vcc_pkg::MODE_IMVP9: quot = quot_prod[25:16] + 10'd1;
      vcc_pkg::MODE_AMD:   quot = {1'b0, quot_prod[36:28]};
      default:             quot = '0;
    endcase
  end

  assign code3_nxt = (cmd2_r && status2_r == vcc_pkg::STATUS_OK && !under2_r) ? quot : '0;
  assign mv3_nxt   = cmd2_r ? '0 : dec2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      mv3_r     <= mv3_nxt;
      code3_r   <= code3_nxt;
      status3_r <= status2_r;
    end
  end

  assign out_valid      = v3_r;
  assign out_millivolts = mv3_r;
  assign out_code_out   = code3_r;
  assign out_status     = status3_r;

endmodule

>>> tb/tb_vid_code_voltage_converter.sv
// ----------------------------------------------------------------------------
// tb_vid_code_voltage_converter
// Self-checking bench for the VID code / voltage converter. Decode and encode
// words are pushed through the valid/ready input with random gaps. Each
// accepted word is predicted from a local copy of the loop registers, and the
// result is checked against the oldest prediction as it leaves the block.
// Register settings change only while the pipe is empty. They cover every
// mode value, full, zero and inverted windows, and the spare indexes.
// ----------------------------------------------------------------------------
module tb_vid_code_voltage_converter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_DECODE = 1'b0;
  localparam logic CMD_ENCODE = 1'b1;
  localparam logic LOOP_A     = 1'b0;
  localparam logic LOOP_B     = 1'b1;

  localparam logic [2:0] CFG_SPARE_6 = 3'd6;
  localparam logic [2:0] CFG_SPARE_7 = 3'd7;
  localparam logic [2:0] MODE_SPARE  = 3'd7;

  localparam int unsigned VR11_TOP_CODE = 'hB2;
  localparam int unsigned AMD_TOP_CODE  = 'hD8;
  localparam logic [vcc_pkg::UV_W-1:0] UV_ALL = '1;

  localparam int HOLD_CYCLES = 60;
  localparam int STUCK_LIMIT = 2000;

  typedef struct {
    logic                      cmd;
    logic                      loop_sel;
    logic [vcc_pkg::VID_W-1:0] vid_code;
    logic [vcc_pkg::UV_W-1:0]  target_uv;
  } conv_req_t;

  typedef struct {
    logic [vcc_pkg::MV_W-1:0]   millivolts;
    logic [vcc_pkg::CODE_W-1:0] code;
    logic [1:0]                 status;
  } conv_res_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_cmd = 1'b0;
  logic                       in_loop_select = 1'b0;
  logic [vcc_pkg::VID_W-1:0]  in_vid_code = '0;
  logic [vcc_pkg::UV_W-1:0]   in_target_uv = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [vcc_pkg::MV_W-1:0]   out_millivolts;
  logic [vcc_pkg::CODE_W-1:0] out_code_out;
  logic [1:0]                 out_status;
  logic                       cfg_wr_en = 1'b0;
  logic [2:0]                 cfg_index = '0;
  logic [vcc_pkg::UV_W-1:0]   cfg_wdata = '0;

  // local copy of the loop registers, indexed by loop select
  logic [2:0]               loop_mode [2];
  logic [vcc_pkg::UV_W-1:0] loop_min_uv [2];
  logic [vcc_pkg::UV_W-1:0] loop_max_uv [2];

  conv_req_t request_q [$];
  conv_res_t conversion_q [$];
  conv_req_t next_word;
  conv_res_t want;

  int   n_queued = 0;
  int   n_accepted = 0;
  int   n_errors = 0;
  int   idle_max = 3;
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  int   stuck_cycles = 0;
  logic word_taken = 1'b0;
  logic result_taken = 1'b0;
  logic hold_req = 1'b0;

  vid_code_voltage_converter u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_loop_select (in_loop_select),
    .in_vid_code    (in_vid_code),
    .in_target_uv   (in_target_uv),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_millivolts (out_millivolts),
    .out_code_out   (out_code_out),
    .out_status     (out_status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic conv_res_t predict_conversion(logic cmd, logic sel,
                                                   logic [vcc_pkg::VID_W-1:0] vid,
                                                   logic [vcc_pkg::UV_W-1:0] tgt);
    conv_res_t   r;
    logic [2:0]  m;
    int unsigned c;
    int unsigned mv;
    int unsigned v;
    r.millivolts = '0;
    r.code = '0;
    r.status = vcc_pkg::STATUS_OK;
    m = loop_mode[sel];
    c = 32'(vid);
    v = 0;
    if (cmd == CMD_DECODE) begin
      case (m)
        vcc_pkg::MODE_VR11: begin
          if (c >= 2 && c <= VR11_TOP_CODE) v = (160000 - (c - 2) * 625 + 50) / 100;
        end
        vcc_pkg::MODE_VR12:  v = (c >= 1) ? 250 + (c - 1) * 5 : 0;
        vcc_pkg::MODE_VR13:  v = (c >= 1) ? 500 + (c - 1) * 10 : 0;
        vcc_pkg::MODE_IMVP9: v = (c >= 1) ? 200 + (c - 1) * 10 : 0;
        vcc_pkg::MODE_AMD: begin
          if (c <= AMD_TOP_CODE) v = (155000 - c * 625 + 50) / 100;
        end
        default: v = 0;
      endcase
      r.millivolts = v[vcc_pkg::MV_W-1:0];
    end else if (tgt == '0) begin
      r.status = vcc_pkg::STATUS_ZERO;
    end else if (tgt > loop_max_uv[sel] || tgt < loop_min_uv[sel]) begin
      r.status = vcc_pkg::STATUS_RANGE;
    end else begin
      mv = 32'(tgt) / 1000;
      case (m)
        vcc_pkg::MODE_VR12:  v = (mv >= 250) ? 1 + (mv - 250 + 2) / 5 : 0;
        vcc_pkg::MODE_VR13:  v = (mv >= 500) ? 1 + (mv - 500 + 5) / 10 : 0;
        vcc_pkg::MODE_IMVP9: v = (mv >= 200) ? 1 + (mv - 200 + 5) / 10 : 0;
        vcc_pkg::MODE_AMD: begin
          if (mv >= 200 && mv <= 1550) v = ((1550 - mv) * 100 + 312) / 625;
        end
        // vr11 and the unused mode values have no encoder
        default: r.status = vcc_pkg::STATUS_UNSUPP;
      endcase
      r.code = v[vcc_pkg::CODE_W-1:0];
    end
    return r;
  endfunction

  function automatic conv_req_t random_request();
    conv_req_t   q;
    int unsigned lo;
    int unsigned hi;
    int unsigned t;
    q.cmd = 1'($urandom_range(0, 1));
    q.loop_sel = 1'($urandom_range(0, 1));
    q.vid_code = 8'($urandom_range(0, 255));
    lo = 32'(loop_min_uv[q.loop_sel]);
    hi = 32'(loop_max_uv[q.loop_sel]);
    case ($urandom_range(0, 9))
      0: t = 0;
      1: t = $urandom();
      2: begin
        case ($urandom_range(0, 3))
          0: t = lo - 1;
          1: t = lo;
          2: t = hi;
          default: t = hi + 1;
        endcase
      end
      3: begin
        // just around the mode floors and the amd ceiling, in mV
        case ($urandom_range(0, 7))
          0: t = 199;
          1: t = 200;
          2: t = 249;
          3: t = 250;
          4: t = 499;
          5: t = 500;
          6: t = 1550;
          default: t = 1551;
        endcase
        t = t * 1000 + $urandom_range(0, 999);
      end
      default: t = (lo <= hi) ? lo + $urandom_range(0, hi - lo) : $urandom();
    endcase
    q.target_uv = t[vcc_pkg::UV_W-1:0];
    return q;
  endfunction

  task automatic post_word(conv_req_t q);
    request_q.push_back(q);
    n_queued++;
  endtask

  task automatic post(logic cmd, logic sel, logic [vcc_pkg::VID_W-1:0] vid,
                      logic [vcc_pkg::UV_W-1:0] tgt);
    conv_req_t q;
    q.cmd = cmd;
    q.loop_sel = sel;
    q.vid_code = vid;
    q.target_uv = tgt;
    post_word(q);
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || conversion_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [vcc_pkg::UV_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      vcc_pkg::CFG_MODE_A:   loop_mode[LOOP_A] = val[2:0];
      vcc_pkg::CFG_MODE_B:   loop_mode[LOOP_B] = val[2:0];
      vcc_pkg::CFG_MIN_UV_A: loop_min_uv[LOOP_A] = val;
      vcc_pkg::CFG_MAX_UV_A: loop_max_uv[LOOP_A] = val;
      vcc_pkg::CFG_MIN_UV_B: loop_min_uv[LOOP_B] = val;
      vcc_pkg::CFG_MAX_UV_B: loop_max_uv[LOOP_B] = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_window(logic [2:0] min_idx, logic [2:0] max_idx);
    int unsigned lo;
    int unsigned hi;
    case ($urandom_range(0, 7))
      0, 1, 2: begin
        lo = 0;
        hi = 32'(UV_ALL);
      end
      3, 4, 5: begin
        lo = $urandom_range(0, 600000);
        hi = $urandom_range(1200000, 32'(UV_ALL));
      end
      6: begin
        lo = $urandom_range(2000000, 32'(UV_ALL));
        hi = $urandom_range(0, 1999999);
      end
      default: begin
        lo = 0;
        hi = 0;
      end
    endcase
    write_reg(min_idx, lo[vcc_pkg::UV_W-1:0]);
    write_reg(max_idx, hi[vcc_pkg::UV_W-1:0]);
  endtask

  // driver: a word goes out at a falling edge once the last one is taken and its random gap is over
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !word_taken)) begin
      word_taken = 1'b0;
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (request_q.size() != 0) begin
        next_word = request_q.pop_front();
        in_cmd <= next_word.cmd;
        in_loop_select <= next_word.loop_sel;
        in_vid_code <= next_word.vid_code;
        in_target_uv <= next_word.target_uv;
        in_valid <= 1'b1;
        send_gap = $urandom_range(0, idle_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure: a short random stall per word, or one long hold
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (result_taken) begin
      result_taken = 1'b0;
      stall_left = $urandom_range(0, idle_max);
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: predict on input accept first, then check the outgoing word
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        conversion_q.push_back(predict_conversion(in_cmd, in_loop_select, in_vid_code,
                                                  in_target_uv));
        word_taken = 1'b1;
        n_accepted++;
      end
      if (out_valid && out_ready) begin
        result_taken = 1'b1;
        if (conversion_q.size() == 0) begin
          $display("%0t: unexpected word mv=%0d code=%0d status=%0d", $time,
                   out_millivolts, out_code_out, out_status);
          n_errors++;
        end else begin
          want = conversion_q.pop_front();
          if (out_millivolts !== want.millivolts) begin
            $display("%0t: millivolts expected %0d got %0d", $time, want.millivolts,
                     out_millivolts);
            n_errors++;
          end
          if (out_code_out !== want.code) begin
            $display("%0t: code_out expected %0d got %0d", $time, want.code, out_code_out);
            n_errors++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
            n_errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("vid_code_voltage_converter test failed");
        $finish;
      end
    end
  end

  initial begin
    loop_mode[LOOP_A] = vcc_pkg::MODE_VR13;
    loop_mode[LOOP_B] = vcc_pkg::MODE_VR13;
    loop_min_uv[LOOP_A] = '0;
    loop_max_uv[LOOP_A] = '0;
    loop_min_uv[LOOP_B] = '0;
    loop_max_uv[LOOP_B] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: vr13 on both loops, zero window
    @(posedge clk);
    post(CMD_DECODE, LOOP_A, 8'd1, '0);
    post(CMD_ENCODE, LOOP_B, 8'd0, 22'd5);
    post(CMD_DECODE, LOOP_B, 8'hFF, '0);
    wait_idle();

    write_reg(vcc_pkg::CFG_MODE_A, vcc_pkg::MODE_VR12);
    write_reg(vcc_pkg::CFG_MODE_B, vcc_pkg::MODE_AMD);
    write_reg(vcc_pkg::CFG_MIN_UV_A, '0);
    write_reg(vcc_pkg::CFG_MAX_UV_A, UV_ALL);
    write_reg(vcc_pkg::CFG_MIN_UV_B, 22'd200000);
    write_reg(vcc_pkg::CFG_MAX_UV_B, 22'd1550999);
    @(posedge clk);
    post(CMD_DECODE, LOOP_A, 8'd0, '0);
    post(CMD_DECODE, LOOP_A, 8'hFF, UV_ALL);
    post(CMD_DECODE, LOOP_B, 8'd0, '0);
    post(CMD_DECODE, LOOP_B, 8'hD8, '0);
    post(CMD_DECODE, LOOP_B, 8'hD9, '0);
    post(CMD_ENCODE, LOOP_A, 8'hFF, '0);
    post(CMD_ENCODE, LOOP_A, 8'd0, UV_ALL);
    post(CMD_ENCODE, LOOP_A, 8'd0, 22'd249999);
    post(CMD_ENCODE, LOOP_A, 8'd0, 22'd252500);
    // zero target wins over a window that excludes it
    post(CMD_ENCODE, LOOP_B, 8'd0, '0);
    post(CMD_ENCODE, LOOP_B, 8'd0, 22'd199999);
    post(CMD_ENCODE, LOOP_B, 8'd0, 22'd1551000);
    post(CMD_ENCODE, LOOP_B, 8'd0, 22'd200000);
    post(CMD_ENCODE, LOOP_B, 8'd0, 22'd1550999);
    wait_idle();

    // vr11 on loop a, unused mode with inverted window on loop b
    write_reg(vcc_pkg::CFG_MODE_A, vcc_pkg::MODE_VR11);
    write_reg(vcc_pkg::CFG_MODE_B, MODE_SPARE);
    write_reg(vcc_pkg::CFG_MIN_UV_B, 22'd5000);
    write_reg(vcc_pkg::CFG_MAX_UV_B, 22'd1000);
    write_reg(CFG_SPARE_6, UV_ALL);
    write_reg(CFG_SPARE_7, UV_ALL);
    @(posedge clk);
    post(CMD_DECODE, LOOP_A, 8'd1, '0);
    post(CMD_DECODE, LOOP_A, 8'd2, '0);
    post(CMD_DECODE, LOOP_A, 8'hB2, '0);
    post(CMD_DECODE, LOOP_A, 8'hB3, '0);
    post(CMD_ENCODE, LOOP_A, 8'd0, 22'd1000000);
    post(CMD_DECODE, LOOP_B, 8'd10, '0);
    post(CMD_ENCODE, LOOP_B, 8'd0, 22'd3000);
    post(CMD_ENCODE, LOOP_B, 8'd0, '0);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      // loop a steps through every mode value, loop b takes a random mode that has an encoder
      write_reg(vcc_pkg::CFG_MODE_A, ph[2:0]);
      write_reg(vcc_pkg::CFG_MODE_B, 3'($urandom_range(1, 4)));
      random_window(vcc_pkg::CFG_MIN_UV_A, vcc_pkg::CFG_MAX_UV_A);
      random_window(vcc_pkg::CFG_MIN_UV_B, vcc_pkg::CFG_MAX_UV_B);
      idle_max = (ph % 4 == 2) ? 0 : 3;
      if (ph == 1) hold_req = 1'b1;
      for (int ch = 0; ch < 4; ch++) begin
        @(posedge clk);
        repeat (25) post_word(random_request());
        if (ph == 3 || $urandom_range(0, 3) == 0) wait_idle();
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("vid_code_voltage_converter test passed");
    end else begin
      $display("vid_code_voltage_converter test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/vcc_pkg.sv
rtl/vcc_decode.sv
rtl/vid_code_voltage_converter.sv
tb/tb_vid_code_voltage_converter.sv
